FILE: src/hsvct_pkg.sv
// Shared types, widths and constants of the HSV color tune pipeline.
package hsvct_pkg;

   localparam int FRAC_BITS  = 12;
   localparam int ONE_W      = FRAC_BITS + 1;
   localparam int DIV_W      = 12;
   localparam int REM_W      = FRAC_BITS + 12;
   localparam int PROD_W     = 2 * FRAC_BITS + 1;
   localparam int CSR_W      = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int HSUM_W     = ((ONE_W > CSR_W) ? ONE_W : CSR_W) + 2;
   localparam int SPROD_W    = ONE_W + CSR_W;
   localparam int H6_W       = ONE_W + 3;
   localparam int ONE_DIV255 = (1 << FRAC_BITS) / 255;
   localparam int ONE_MOD255 = (1 << FRAC_BITS) % 255;

   localparam logic [ONE_W-1:0] ONE_FX = ONE_W'(1) << FRAC_BITS;

   localparam logic [CSR_IDX_W-1:0] CSR_HUE_OFFSET   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAT_GAIN     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_OFFSET = 2'd2;

   localparam logic [CSR_W-1:0] HUE_OFFSET_RESET   = '0;
   localparam logic [CSR_W-1:0] SAT_GAIN_RESET     = CSR_W'(1) << FRAC_BITS;
   localparam logic [CSR_W-1:0] VALUE_OFFSET_RESET = '0;

   typedef enum logic [2:0] {
      DOM_RED     = 3'd0,
      DOM_YELLOW  = 3'd1,
      DOM_GREEN   = 3'd2,
      DOM_CYAN    = 3'd3,
      DOM_BLUE    = 3'd4,
      DOM_MAGENTA = 3'd5
   } hue_domain_type;

   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
   } pixel_out_type;

   typedef struct packed {
      logic [CSR_W-1:0] hue_offset;
      logic [CSR_W-1:0] sat_gain;
      logic [CSR_W-1:0] value_offset;
   } csr_type;

   typedef struct packed {
      logic [REM_W-1:0] h_rem;
      logic [DIV_W-1:0] h_div;
      logic [ONE_W-1:0] h_quo;
      logic [REM_W-1:0] s_rem;
      logic [DIV_W-1:0] s_div;
      logic [ONE_W-1:0] s_quo;
      logic [ONE_W-1:0] val;
      logic             grey;
   } div_pipe_type;

endpackage

FILE: src/hsvct_front.sv
// Front stage: max/min, value, and dividends and divisors for hue and saturation.
module hsvct_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  hsvct_pkg::pixel_in_type pixel,
   output logic                   out_valid,
   output hsvct_pkg::div_pipe_type out_data
);

   logic [7:0]  r, g, b, mx, mn, d;
   logic [10:0] n, d6;
   logic [15:0] vt;
   logic [16:0] vq;
   logic        valid_ff;
   hsvct_pkg::div_pipe_type data_in, data_ff;

   always_comb begin
      r  = pixel.red_in;
      g  = pixel.green_in;
      b  = pixel.blue_in;
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      d  = mx - mn;
      d6 = (11'(d) << 2) + (11'(d) << 1);
      if (r == mx) begin
         n = (g >= b) ? 11'(g) - 11'(b) : d6 + 11'(g) - 11'(b);
      end else if (g == mx) begin
         n = (11'(d) << 1) + 11'(b) - 11'(r);
      end else begin
         n = (11'(d) << 2) + 11'(r) - 11'(g);
      end
      vt = 16'(16'(mx) * 16'(hsvct_pkg::ONE_MOD255)) + 16'd254;
      vq = 17'(vt) + 17'(vt >> 8) + 17'd1;

      data_in.h_rem = (hsvct_pkg::REM_W'(n) << (hsvct_pkg::FRAC_BITS + 1))
                      + hsvct_pkg::REM_W'(d6);
      data_in.h_div = (hsvct_pkg::DIV_W'(d) << 3) + (hsvct_pkg::DIV_W'(d) << 2);
      data_in.h_quo = '0;
      data_in.s_rem = (hsvct_pkg::REM_W'(d) << (hsvct_pkg::FRAC_BITS + 1))
                      + hsvct_pkg::REM_W'(mx);
      data_in.s_div = hsvct_pkg::DIV_W'(mx) << 1;
      data_in.s_quo = '0;
      data_in.val   = hsvct_pkg::ONE_W'(hsvct_pkg::ONE_W'(mx)
                      * hsvct_pkg::ONE_W'(hsvct_pkg::ONE_DIV255))
                      + hsvct_pkg::ONE_W'(vq >> 8);
      data_in.grey  = (d == 8'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: src/hsvct_div_stage.sv
// One quotient bit of the hue and saturation restoring dividers.
module hsvct_div_stage #(
   parameter int BIT = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  hsvct_pkg::div_pipe_type in_data,
   output logic                    out_valid,
   output hsvct_pkg::div_pipe_type out_data
);

   logic [hsvct_pkg::REM_W-1:0] h_cmp, s_cmp;
   logic                        valid_ff;
   hsvct_pkg::div_pipe_type     data_in, data_ff;

   always_comb begin
      h_cmp   = hsvct_pkg::REM_W'(in_data.h_div) << BIT;
      s_cmp   = hsvct_pkg::REM_W'(in_data.s_div) << BIT;
      data_in = in_data;
      if (in_data.h_rem >= h_cmp) begin
         data_in.h_rem      = in_data.h_rem - h_cmp;
         data_in.h_quo[BIT] = 1'b1;
      end
      if (in_data.s_rem >= s_cmp) begin
         data_in.s_rem      = in_data.s_rem - s_cmp;
         data_in.s_quo[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: src/hsvct_back.sv
// Back stages: hue, saturation and value adjust, then conversion to RGB.
module hsvct_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   input  hsvct_pkg::div_pipe_type  in_data,
   input  hsvct_pkg::csr_type       csr,
   output logic                     out_valid,
   output hsvct_pkg::pixel_out_type out_pixel
);

   localparam int F  = hsvct_pkg::FRAC_BITS;
   localparam int UW = hsvct_pkg::ONE_W;
   localparam int PW = hsvct_pkg::PROD_W;
   localparam int HW = hsvct_pkg::HSUM_W;

   logic [UW-1:0]          h0, s0, h1_in, v1_in, h1_ff, v1_ff;
   logic signed [HW-1:0]   hsum, vsum;
   logic [hsvct_pkg::SPROD_W-1:0] sp1_in, sp1_ff, sp_sh;
   logic                   vld1_ff, vld2_ff, vld3_ff, vld4_ff, vld5_ff;

   logic [UW-1:0]          v2_in, s2_in, f2_in, v2_ff, s2_ff, f2_ff;
   logic [hsvct_pkg::H6_W-1:0] h6;
   logic [2:0]             kraw;
   hsvct_pkg::hue_domain_type k2_in, k2_ff, k3_ff, k4_ff;

   logic [PW-1:0]          c3_in, hi3_in, c3_ff, hi3_ff;
   logic [UW-1:0]          f3_ff;

   logic [PW+UW-1:0]       rprod;
   logic [PW-1:0]          ramp4_in, lo4_in, ramp4_ff, lo4_ff, hi4_ff;

   logic [PW-1:0]          rise, fall, xr, xg, xb;
   logic [PW+7:0]          yr, yg, yb;
   hsvct_pkg::pixel_out_type pix_in, pix_ff;

   always_comb begin
      h0    = in_data.grey ? '0 : in_data.h_quo;
      s0    = in_data.grey ? '0 : in_data.s_quo;
      hsum  = $signed(HW'(h0)) + HW'($signed(csr.hue_offset));
      vsum  = $signed(HW'(in_data.val)) + HW'($signed(csr.value_offset));
      if (hsum < 0) h1_in = '0;
      else if (hsum > $signed(HW'(hsvct_pkg::ONE_FX))) h1_in = hsvct_pkg::ONE_FX;
      else h1_in = UW'(hsum);
      if (vsum < 0) v1_in = '0;
      else if (vsum > $signed(HW'(hsvct_pkg::ONE_FX))) v1_in = hsvct_pkg::ONE_FX;
      else v1_in = UW'(vsum);
      sp1_in = hsvct_pkg::SPROD_W'(s0) * hsvct_pkg::SPROD_W'(csr.sat_gain);
   end

   always_comb begin
      sp_sh = sp1_ff >> F;
      s2_in = (sp_sh > hsvct_pkg::SPROD_W'(hsvct_pkg::ONE_FX)) ? hsvct_pkg::ONE_FX
                                                              : UW'(sp_sh);
      v2_in = v1_ff;
      h6    = (hsvct_pkg::H6_W'(h1_ff) << 2) + (hsvct_pkg::H6_W'(h1_ff) << 1);
      kraw  = 3'(h6 >> F);
      if (kraw > 3'(hsvct_pkg::DOM_MAGENTA)) kraw = 3'(hsvct_pkg::DOM_MAGENTA);
      k2_in = hsvct_pkg::hue_domain_type'(kraw);
      f2_in = UW'(h6 - (hsvct_pkg::H6_W'(kraw) << F));
   end

   always_comb begin
      c3_in  = PW'(v2_ff) * PW'(s2_ff);
      hi3_in = PW'(v2_ff) << F;
   end

   always_comb begin
      rprod    = (PW + UW)'(c3_ff) * (PW + UW)'(f3_ff);
      ramp4_in = PW'(rprod >> F);
      lo4_in   = hi3_ff - c3_ff;
   end

   always_comb begin
      rise = lo4_ff + ramp4_ff;
      fall = hi4_ff - ramp4_ff;
      unique case (k4_ff)
         hsvct_pkg::DOM_RED: begin
            xr = hi4_ff; xg = rise;   xb = lo4_ff;
         end
         hsvct_pkg::DOM_YELLOW: begin
            xr = fall;   xg = hi4_ff; xb = lo4_ff;
         end
         hsvct_pkg::DOM_GREEN: begin
            xr = lo4_ff; xg = hi4_ff; xb = rise;
         end
         hsvct_pkg::DOM_CYAN: begin
            xr = lo4_ff; xg = fall;   xb = hi4_ff;
         end
         hsvct_pkg::DOM_BLUE: begin
            xr = rise;   xg = lo4_ff; xb = hi4_ff;
         end
         default: begin
            xr = hi4_ff; xg = lo4_ff; xb = fall;
         end
      endcase
      yr = ((PW + 8)'(xr) << 8) - (PW + 8)'(xr);
      yg = ((PW + 8)'(xg) << 8) - (PW + 8)'(xg);
      yb = ((PW + 8)'(xb) << 8) - (PW + 8)'(xb);
      pix_in.red_out   = 8'(yr >> (2 * F));
      pix_in.green_out = 8'(yg >> (2 * F));
      pix_in.blue_out  = 8'(yb >> (2 * F));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         vld1_ff <= in_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
         vld4_ff <= vld3_ff;
         vld5_ff <= vld4_ff;
      end
      h1_ff    <= h1_in;
      v1_ff    <= v1_in;
      sp1_ff   <= sp1_in;
      v2_ff    <= v2_in;
      s2_ff    <= s2_in;
      k2_ff    <= k2_in;
      f2_ff    <= f2_in;
      c3_ff    <= c3_in;
      hi3_ff   <= hi3_in;
      k3_ff    <= k2_ff;
      f3_ff    <= f2_ff;
      ramp4_ff <= ramp4_in;
      lo4_ff   <= lo4_in;
      hi4_ff   <= hi3_ff;
      k4_ff    <= k3_ff;
      pix_ff   <= pix_in;
   end

   assign out_valid = vld5_ff;
   assign out_pixel = pix_ff;

endmodule

FILE: src/hsv_hexcone_color_tune.sv
// Top level of the HSV hexcone color tune pipeline.
// One pixel is taken on every clock that start is high; busy stays low. Each
// pixel passes through the front, divider and back stages and leaves with
// rsp_strobe high for one cycle, which the receiver cannot hold off. The depth
// is set by the bit-per-stage hue and saturation dividers. Configuration writes
// are always accepted and should be made while no pixel is in flight.
module hsv_hexcone_color_tune (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  hsvct_pkg::pixel_in_type             req_pixel,
   output logic                                rsp_strobe,
   output hsvct_pkg::pixel_out_type            rsp_pixel,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [hsvct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hsvct_pkg::CSR_W-1:0]         csr_data
);

   localparam int NSTG = hsvct_pkg::ONE_W;

   hsvct_pkg::csr_type      csr_ff, csr_in;
   hsvct_pkg::div_pipe_type stg_data [NSTG+1];
   logic                    stg_valid [NSTG+1];

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_comb begin
      csr_in = csr_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == hsvct_pkg::CSR_HUE_OFFSET) csr_in.hue_offset = csr_data;
         if (csr_index == hsvct_pkg::CSR_SAT_GAIN) csr_in.sat_gain = csr_data;
         if (csr_index == hsvct_pkg::CSR_VALUE_OFFSET) csr_in.value_offset = csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.hue_offset   <= hsvct_pkg::HUE_OFFSET_RESET;
         csr_ff.sat_gain     <= hsvct_pkg::SAT_GAIN_RESET;
         csr_ff.value_offset <= hsvct_pkg::VALUE_OFFSET_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   hsvct_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .pixel     (req_pixel),
      .out_valid (stg_valid[0]),
      .out_data  (stg_data[0])
   );

   for (genvar j = 0; j < NSTG; j++) begin : g_div
      hsvct_div_stage #(.BIT(NSTG - 1 - j)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[j]),
         .in_data   (stg_data[j]),
         .out_valid (stg_valid[j+1]),
         .out_data  (stg_data[j+1])
      );
   end

   hsvct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stg_valid[NSTG]),
      .in_data   (stg_data[NSTG]),
      .csr       (csr_ff),
      .out_valid (rsp_strobe),
      .out_pixel (rsp_pixel)
   );

endmodule

FILE: tb/hsv_hexcone_color_tune_test.sv
// Self-checking testbench of the HSV hexcone color tune pipeline.
`timescale 1ns / 100ps

module hsv_hexcone_color_tune_test;

   localparam int PIPE_DEPTH = hsvct_pkg::FRAC_BITS + 7;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [hsvct_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      hsvct_pkg::pixel_in_type  px;
      bit                       typed;
      hsvct_pkg::pixel_out_type want;
   } pixel_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   hsvct_pkg::pixel_in_type req_pixel = '0;
   logic rsp_strobe;
   hsvct_pkg::pixel_out_type rsp_pixel;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [hsvct_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [hsvct_pkg::CSR_W-1:0] csr_data = '0;

   logic [hsvct_pkg::CSR_W-1:0] hue_shift, sat_scale, val_shift;
   hsvct_pkg::pixel_out_type expected_pixels[$];
   int errors = 0;
   int cycles = 0;
   pixel_row_type pixel_rows[15];

   hsv_hexcone_color_tune dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycles);
      errors++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_pixels.size() == 0) begin
            report_mismatch("unexpected pixel", int'(rsp_pixel), 0);
         end else begin
            hsvct_pkg::pixel_out_type w;
            w = expected_pixels.pop_front();
            if (rsp_pixel.red_out !== w.red_out)
               report_mismatch("red", rsp_pixel.red_out, w.red_out);
            if (rsp_pixel.green_out !== w.green_out)
               report_mismatch("green", rsp_pixel.green_out, w.green_out);
            if (rsp_pixel.blue_out !== w.blue_out)
               report_mismatch("blue", rsp_pixel.blue_out, w.blue_out);
         end
      end
   end

   function automatic logic [7:0] to_channel(longint x);
      longint q;
      if (x <= 0) return 8'd0;
      q = (x * 255) >>> (2 * hsvct_pkg::FRAC_BITS);
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function automatic longint unit_clamp(longint x);
      longint one;
      one = longint'(1) << hsvct_pkg::FRAC_BITS;
      return (x < 0) ? 0 : ((x > one) ? one : x);
   endfunction

   function automatic hsvct_pkg::pixel_out_type tune_pixel(hsvct_pkg::pixel_in_type p);
      longint one, r, g, b, mx, mn, d, n, h, s, v, hi, c, lo, f, ramp, rise, fall, k;
      hsvct_pkg::pixel_out_type o;
      one = longint'(1) << hsvct_pkg::FRAC_BITS;
      r = p.red_in; g = p.green_in; b = p.blue_in;
      mx = (r > g) ? r : g;
      if (b > mx) mx = b;
      mn = (r < g) ? r : g;
      if (b < mn) mn = b;
      d = mx - mn;
      v = (mx * one + 254) / 255;
      s = 0;
      h = 0;
      if (mx > 0 && d > 0) begin
         s = (2 * d * one + mx) / (2 * mx);
         if (r == mx) begin
            n = g - b;
            if (n < 0) n += 6 * d;
         end else if (g == mx) begin
            n = 2 * d + b - r;
         end else begin
            n = 4 * d + r - g;
         end
         h = (2 * n * one + 6 * d) / (12 * d);
      end
      h = unit_clamp(h + longint'($signed(hue_shift)));
      s = (s * longint'(sat_scale)) >>> hsvct_pkg::FRAC_BITS;
      if (s > one) s = one;
      v = unit_clamp(v + longint'($signed(val_shift)));
      hi = v * one;
      c = v * s;
      lo = hi - c;
      k = (6 * h) >>> hsvct_pkg::FRAC_BITS;
      if (k > 5) k = 5;
      f = 6 * h - k * one;
      ramp = (c * f) >>> hsvct_pkg::FRAC_BITS;
      rise = lo + ramp;
      fall = hi - ramp;
      case (hsvct_pkg::hue_domain_type'(k[2:0]))
         hsvct_pkg::DOM_RED:
            o = '{to_channel(hi), to_channel(rise), to_channel(lo)};
         hsvct_pkg::DOM_YELLOW:
            o = '{to_channel(fall), to_channel(hi), to_channel(lo)};
         hsvct_pkg::DOM_GREEN:
            o = '{to_channel(lo), to_channel(hi), to_channel(rise)};
         hsvct_pkg::DOM_CYAN:
            o = '{to_channel(lo), to_channel(fall), to_channel(hi)};
         hsvct_pkg::DOM_BLUE:
            o = '{to_channel(rise), to_channel(lo), to_channel(hi)};
         default:
            o = '{to_channel(hi), to_channel(lo), to_channel(fall)};
      endcase
      return o;
   endfunction

   task automatic write_csr(logic [hsvct_pkg::CSR_IDX_W-1:0] idx,
                            logic [hsvct_pkg::CSR_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         hsvct_pkg::CSR_HUE_OFFSET: hue_shift = val;
         hsvct_pkg::CSR_SAT_GAIN: sat_scale = val;
         hsvct_pkg::CSR_VALUE_OFFSET: val_shift = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain_pipe();
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 2) @(posedge clock);
   endtask

   // one item; holds start high when the next one follows without a gap
   task automatic send_pixel(hsvct_pkg::pixel_in_type p, hsvct_pkg::pixel_out_type want,
                             bit typed, int gap);
      start <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (busy);
      expected_pixels.push_back(typed ? want : tune_pixel(p));
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic hsvct_pkg::pixel_in_type random_pixel();
      hsvct_pkg::pixel_in_type p;
      logic [7:0] a;
      p = 24'($urandom);
      a = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      case ($urandom_range(0, 7))
         0: p = '{a, a, a};
         1: p = '{a, p.green_in, a};
         2: begin
            p.red_in = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            p.blue_in = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
         end
         default: ;
      endcase
      return p;
   endfunction

   task automatic run_phase(int count);
      int burst, gap;
      burst = 0;
      foreach (pixel_rows[i])
         send_pixel(pixel_rows[i].px, '0, 1'b0, 0);
      for (int i = 0; i < count; i++) begin
         gap = 0;
         if (burst == 0) begin
            burst = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         end
         burst--;
         send_pixel(random_pixel(), '0, 1'b0, (i == count - 1) ? 1 : gap);
      end
      drain_pipe();
   endtask

   initial begin
      pixel_rows = '{
         '{'{8'd0, 8'd0, 8'd0}, 1'b1, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd255, 8'd255, 8'd255}, 1'b1, '{8'd255, 8'd255, 8'd255}},
         '{'{8'd128, 8'd128, 8'd128}, 1'b1, '{8'd128, 8'd128, 8'd128}},
         '{'{8'd255, 8'd0, 8'd0}, 1'b1, '{8'd255, 8'd0, 8'd0}},
         '{'{8'd0, 8'd255, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd0, 8'd0, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd255, 8'd255, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd0, 8'd255, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd255, 8'd0, 8'd255}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd1, 8'd0, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd255, 8'd254, 8'd0}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd0, 8'd1, 8'd1}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd200, 8'd50, 8'd200}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd10, 8'd20, 8'd30}, 1'b0, '{8'd0, 8'd0, 8'd0}},
         '{'{8'd255, 8'd0, 8'd1}, 1'b0, '{8'd0, 8'd0, 8'd0}}
      };
      hue_shift = hsvct_pkg::HUE_OFFSET_RESET;
      sat_scale = hsvct_pkg::SAT_GAIN_RESET;
      val_shift = hsvct_pkg::VALUE_OFFSET_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (pixel_rows[i])
         send_pixel(pixel_rows[i].px, pixel_rows[i].want, pixel_rows[i].typed,
                    (i == $size(pixel_rows) - 1) ? 1 : $urandom_range(0, 2));
      drain_pipe();
      run_phase(135);

      write_csr(hsvct_pkg::CSR_HUE_OFFSET, 14'd4096);
      write_csr(hsvct_pkg::CSR_SAT_GAIN, 14'd16383);
      write_csr(hsvct_pkg::CSR_VALUE_OFFSET, -14'sd4096);
      run_phase(135);
      write_csr(hsvct_pkg::CSR_HUE_OFFSET, -14'sd4096);
      write_csr(hsvct_pkg::CSR_SAT_GAIN, 14'd0);
      write_csr(hsvct_pkg::CSR_VALUE_OFFSET, 14'd4096);
      run_phase(135);
      write_csr(hsvct_pkg::CSR_HUE_OFFSET, 14'h1FFF);
      write_csr(hsvct_pkg::CSR_SAT_GAIN, 14'd2048);
      write_csr(hsvct_pkg::CSR_VALUE_OFFSET, 14'h2000);
      run_phase(135);
      write_csr(hsvct_pkg::CSR_HUE_OFFSET, 14'h2000);
      write_csr(hsvct_pkg::CSR_VALUE_OFFSET, 14'h1FFF);
      write_csr(CSR_UNUSED, 14'h3FFF);
      run_phase(135);
      for (int ph = 0; ph < 7; ph++) begin
         write_csr(hsvct_pkg::CSR_HUE_OFFSET, 14'($signed($urandom_range(0, 8192)) - 4096));
         write_csr(hsvct_pkg::CSR_SAT_GAIN,
                   ($urandom_range(0, 1) != 0) ? 14'($urandom_range(2048, 8192))
                                               : 14'($urandom));
         write_csr(hsvct_pkg::CSR_VALUE_OFFSET,
                   14'($signed($urandom_range(0, 2048)) - 1024));
         run_phase(135);
      end

      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
